// File: hw/rtl/generation_handle_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the generation handle allocator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GENERATION_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATION_HANDLE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define GHA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("generation_handle_allocator: same-cycle check failed");

// next-cycle implication
`define GHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("generation_handle_allocator: next-cycle check failed");

`endif

// File: hw/rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the generation handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 1024;

    localparam int GEN_W       = 16;   // generation counter
    localparam int IDX_FIELD_W = 16;   // slot index field of a handle
    localparam int HANDLE_W    = 32;
    localparam int WORD_BITS   = 32;   // slots per occupancy word
    localparam int WORD_SHIFT  = 5;    // log2(WORD_BITS)

    localparam int IN_USER_W  = 2;     // mode
    localparam int IN_DATA_W  = 32;    // handle
    localparam int OUT_DATA_W = 40;    // new_handle, alloc_ok, still_waiting, pad

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_DONE  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // lowest free slot within one occupancy word
    typedef struct packed {
        logic                  found;
        logic [WORD_SHIFT-1:0] pos;
    } free_hit_t;

endpackage

`default_nettype wire

// File: hw/rtl/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/gha_first_free.sv
// ----------------------------------------------------------------------------
// gha_first_free
// Priority encoder: lowest set bit of one free-slot word.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_first_free (
    input  wire logic [gha_pkg::WORD_BITS-1:0] free_bits,
    output gha_pkg::free_hit_t                 hit
);

    import gha_pkg::*;

    always_comb
    begin
        hit.found = |free_bits;
        hit.pos   = '0;
        // scan downward so the lowest set bit wins
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                hit.pos = WORD_SHIFT'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/generation_handle_allocator.sv
// Path (accept to result beat): query/done go S_LOOK then S_RESULT, an out-of-range
//   index goes straight to S_RESULT; allocate walks S_SCAN over fully used 32-slot
//   words from the hint, then S_ALLOC and S_RESULT; a full table skips S_ALLOC.
// Flow: one item at a time; next item accepted the cycle after the result is queued.
// Clear all: zero sweep, one table entry written per cycle, then a zero result beat.
// Reset: same sweep with s_axis_tready low, no result beat.
// ----------------------------------------------------------------------------
// generation_handle_allocator
// Generational handle table: allocate, query, done and clear on a 16-bit
// generation counter per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module generation_handle_allocator #(
    parameter int TABLE_ENTRIES = gha_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [gha_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] handle
    input  wire logic [gha_pkg::IN_USER_W-1:0]  s_axis_tuser,  // [1:0] mode
    // result
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [gha_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [31:0] new_handle,
                                                               // [32] alloc_ok,
                                                               // [33] still_waiting,
                                                               // [39:34] zero
);

    import gha_pkg::*;

    // ------------------------------------------------------------------
    // Storage layout
    //   gen RAM : TABLE_ENTRIES x 16, generation counter per slot
    //   occ RAM : NWORDS x 32, slot-in-use bits (= counter bit 0)
    // The occupancy RAM lets allocate look at 32 slots per read. The
    // first-free hint points at the lowest word that may hold a free slot;
    // every word below it is completely in use.
    // ------------------------------------------------------------------
    localparam int IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int NWORDS     = (TABLE_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LAST_BITS  = TABLE_ENTRIES - (NWORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(NWORDS - 1);
    localparam int RES_W = HANDLE_W + 2;

    // one-hot sequencer
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLEAR  = 6'b000010,   // zero sweep over both RAMs
        S_SCAN   = 6'b000100,   // occupancy word back, look for a free bit
        S_ALLOC  = 6'b001000,   // counter back, bump it and mark the slot used
        S_LOOK   = 6'b010000,   // counter back for query / done
        S_RESULT = 6'b100000    // hand result to the output register
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                sweep_cmd_reg, sweep_cmd_next;   // sweep came from a clear item
    logic [WA_W-1:0]     hint_reg, hint_next;
    logic [WA_W-1:0]     scan_ptr_reg, scan_ptr_next;
    mode_t               mode_reg, mode_next;
    logic [GEN_W-1:0]    tag_reg, tag_next;               // generation of the request
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [RES_W-1:0]    res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // RAM ports
    logic                 gen_we;
    logic [IDX_W-1:0]     gen_waddr, gen_raddr;
    logic [GEN_W-1:0]     gen_wdata, gen_rdata;
    logic                 occ_we;
    logic [WA_W-1:0]      occ_waddr, occ_raddr;
    logic [WORD_BITS-1:0] occ_wdata, occ_rdata;

    // request decode
    logic                 in_range_in;
    logic [IDX_W-1:0]     idx_in;
    logic [WA_W-1:0]      word_in;

    // slot helpers
    logic [WA_W-1:0]       slot_word;
    logic [WORD_SHIFT-1:0] slot_bit;
    logic [WORD_BITS-1:0]  slot_mask;
    logic [GEN_W-1:0]      gen_inc;
    logic                  gen_match;

    // scan
    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] free_bits;
    free_hit_t            hit;
    logic [IDX_W-1:0]     hit_slot;

    gha_ram #(
        .WIDTH (GEN_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    gha_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .raddr (occ_raddr),
        .rdata (occ_rdata)
    );

    // padding bits of the last word never count as free
    assign scan_mask = (scan_ptr_reg == LAST_WORD) ? LAST_MASK : '1;
    assign free_bits = ~occ_rdata & scan_mask;

    gha_first_free u_first_free (
        .free_bits (free_bits),
        .hit       (hit)
    );

    assign hit_slot    = IDX_W'({scan_ptr_reg, hit.pos});
    assign in_range_in = {1'b0, s_axis_tdata[IDX_FIELD_W-1:0]} <
                         (IDX_FIELD_W + 1)'(TABLE_ENTRIES);
    assign idx_in      = IDX_W'(s_axis_tdata[IDX_FIELD_W-1:0]);
    assign word_in     = WA_W'(32'(idx_in) >> WORD_SHIFT);
    assign slot_word   = WA_W'(32'(slot_reg) >> WORD_SHIFT);
    assign slot_bit    = WORD_SHIFT'(32'(slot_reg));
    assign slot_mask   = WORD_BITS'(1) << slot_bit;
    assign gen_inc     = gen_rdata + GEN_W'(1);
    assign gen_match   = (gen_rdata == tag_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        sweep_cmd_next = sweep_cmd_reg;
        hint_next      = hint_reg;
        scan_ptr_next  = scan_ptr_reg;
        mode_next      = mode_reg;
        tag_next       = tag_reg;
        slot_next      = slot_reg;
        word_next      = word_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;

        gen_we    = 1'b0;
        gen_waddr = slot_reg;
        gen_wdata = gen_inc;
        gen_raddr = slot_reg;
        occ_we    = 1'b0;
        occ_waddr = slot_word;
        occ_wdata = occ_rdata;
        occ_raddr = hint_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next = mode_t'(s_axis_tuser);
                    tag_next  = s_axis_tdata[HANDLE_W-1:IDX_FIELD_W];
                    slot_next = idx_in;
                    res_next  = '0;
                    unique case (mode_t'(s_axis_tuser))
                        MODE_ALLOC:
                        begin
                            occ_raddr     = hint_reg;
                            scan_ptr_next = hint_reg;
                            state_next    = S_SCAN;
                        end
                        MODE_QUERY, MODE_DONE:
                        begin
                            gen_raddr  = idx_in;
                            occ_raddr  = word_in;
                            state_next = in_range_in ? S_LOOK : S_RESULT;
                        end
                        MODE_CLEAR:
                        begin
                            clr_cnt_next   = '0;
                            sweep_cmd_next = 1'b1;
                            hint_next      = '0;
                            state_next     = S_CLEAR;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                gen_we    = 1'b1;
                gen_waddr = clr_cnt_reg;
                gen_wdata = '0;
                occ_we    = (32'(clr_cnt_reg) < NWORDS);
                occ_waddr = WA_W'(clr_cnt_reg);
                occ_wdata = '0;
                if (clr_cnt_reg == LAST_IDX)
                begin
                    res_next   = '0;
                    state_next = sweep_cmd_reg ? S_RESULT : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end

            S_SCAN:
            begin
                if (hit.found)
                begin
                    slot_next  = hit_slot;
                    gen_raddr  = hit_slot;
                    word_next  = occ_rdata;
                    hint_next  = scan_ptr_reg;
                    state_next = S_ALLOC;
                end
                else if (scan_ptr_reg == LAST_WORD)
                begin
                    // table full
                    hint_next  = scan_ptr_reg;
                    res_next   = '0;
                    state_next = S_RESULT;
                end
                else
                begin
                    scan_ptr_next = scan_ptr_reg + WA_W'(1);
                    occ_raddr     = scan_ptr_reg + WA_W'(1);
                    hint_next     = scan_ptr_reg + WA_W'(1);
                end
            end

            S_ALLOC:
            begin
                gen_we     = 1'b1;
                gen_wdata  = gen_inc;
                occ_we     = 1'b1;
                occ_waddr  = scan_ptr_reg;
                occ_wdata  = word_reg | slot_mask;
                res_next   = {1'b0, 1'b1, gen_inc, IDX_FIELD_W'(slot_reg)};
                state_next = S_RESULT;
            end

            S_LOOK:
            begin
                res_next = '0;
                if (mode_reg == MODE_QUERY)
                begin
                    res_next = {gen_match, 1'b0, HANDLE_W'(0)};
                end
                else if (gen_match)
                begin
                    // done: bump the counter, occupancy follows its low bit
                    gen_we    = 1'b1;
                    gen_wdata = gen_inc;
                    occ_we    = 1'b1;
                    occ_wdata = gen_inc[0] ? (occ_rdata | slot_mask)
                                           : (occ_rdata & ~slot_mask);
                    if (!gen_inc[0] && (slot_word < hint_reg))
                    begin
                        hint_next = slot_word;
                    end
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_DATA_W'(res_reg);
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state; reset starts the zero sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            sweep_cmd_reg <= 1'b0;
            hint_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            sweep_cmd_reg <= sweep_cmd_next;
            hint_reg      <= hint_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        scan_ptr_reg <= scan_ptr_next;
        mode_reg     <= mode_next;
        tag_reg      <= tag_next;
        slot_reg     <= slot_next;
        word_reg     <= word_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks of the generation handle allocator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "generation_handle_allocator_assert.svh"

module gha_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [gha_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [31:0] handle
    input wire logic [gha_pkg::IN_USER_W-1:0]   s_axis_tuser,   // [1:0] mode
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [gha_pkg::OUT_DATA_W-1:0]  m_axis_tdata    // [31:0] new_handle,
                                                                // [32] alloc_ok,
                                                                // [33] still_waiting
);

    import gha_pkg::*;

    logic       in_beat, out_beat;
    logic [1:0] open_reg;   // items accepted whose result beat has not gone out
    logic       req_seen;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign req_seen = (s_axis_tdata != '0) || (s_axis_tuser != '0) || 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + 2'(in_beat && req_seen) - 2'(out_beat);
        end
    end

    // every result beat belongs to an accepted item
    `GHA_ASSERT_SAME(a_result_has_item, m_axis_tvalid, open_reg != 2'd0)
    // a failed or non-allocate result carries a zero handle
    `GHA_ASSERT_SAME(a_fail_zero_handle, m_axis_tvalid && !m_axis_tdata[HANDLE_W],
                     m_axis_tdata[HANDLE_W-1:0] == '0)
    // an allocated slot is in use: odd generation, never alongside a query answer
    `GHA_ASSERT_SAME(a_alloc_odd_gen, m_axis_tvalid && m_axis_tdata[HANDLE_W],
                     m_axis_tdata[IDX_FIELD_W] && !m_axis_tdata[HANDLE_W+1])
    // a stalled result beat holds
    `GHA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind generation_handle_allocator gha_checker u_gha_checker (.*);

`default_nettype wire

// File: sim/tb_generation_handle_allocator.sv
// ----------------------------------------------------------------------------
// tb_generation_handle_allocator
// Self-checking bench for the generation handle allocator. Requests go in as
// beats on the slave stream and each accepted request is run through a
// software copy of the generation table. The answer it predicts is queued and
// compared field by field with the next result beat. Stimulus runs in phases:
// a short directed sequence, a run without stalls that cycles one slot between
// in use and free, a fill of the whole table past full, then a random mix of
// mostly well-formed traffic. Both streams stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_generation_handle_allocator;

    import gha_pkg::*;

    localparam int TABLE_ENTRIES  = DEFAULT_TABLE_ENTRIES;
    localparam int OK_BIT         = HANDLE_W;       // alloc_ok in the result beat
    localparam int WAIT_BIT       = HANDLE_W + 1;   // still_waiting
    localparam int RANDOM_ITEMS   = 800;
    localparam int CYCLE_ROUNDS   = 100;            // query + done/alloc pairs on slot 0
    localparam int IDLE_PCT       = 18;
    localparam int HOLD_CYCLES    = 400;            // one long sink stall
    // Longest quiet stretch of a good run is the reset or clear sweep
    // or the long sink stall; the limit sits above both together.
    localparam int WATCHDOG_LIMIT = 4 * TABLE_ENTRIES + 2 * HOLD_CYCLES;
    localparam int DRAIN_CYCLES   = 4 + TABLE_ENTRIES / WORD_BITS + 8;

    // what one result beat should carry
    typedef struct {
        logic [HANDLE_W-1:0] new_handle;
        logic                alloc_ok;
        logic                still_waiting;
    } answer_t;

    // ------------------------------------------------------------------------
    // Generation ledger: private copy of the slot counters, predicts each
    // answer on accept and checks result beats in order.
    // ------------------------------------------------------------------------
    class generation_ledger;
        bit [GEN_W-1:0] gen_count [TABLE_ENTRIES];
        answer_t        awaited [$];
        int unsigned    errors;
        int unsigned    peak_slot;    // highest slot handed out since the last clear

        function new();
            wipe();
            errors = 0;
        endfunction

        function void wipe();
            foreach (gen_count[i])
                gen_count[i] = '0;
            peak_slot = 0;
        endfunction

        function bit [GEN_W-1:0] slot_gen(int unsigned slot);
            return gen_count[slot];
        endfunction

        function int unsigned pending_count();
            return awaited.size();
        endfunction

        function void note_request(mode_t mode, logic [HANDLE_W-1:0] handle);
            answer_t          want;
            int unsigned      idx;
            logic [GEN_W-1:0] gen;
            bit               hit;
            want.new_handle    = '0;
            want.alloc_ok      = 1'b0;
            want.still_waiting = 1'b0;
            idx = handle[IDX_FIELD_W-1:0];
            gen = handle[HANDLE_W-1:IDX_FIELD_W];
            // raw compare: an even (free) counter matches too
            hit = (idx < TABLE_ENTRIES) && (gen_count[idx] == gen);
            case (mode)
                MODE_ALLOC:
                    for (int i = 0; i < TABLE_ENTRIES && !want.alloc_ok; i++)
                        if (!gen_count[i][0])
                        begin
                            gen_count[i]++;
                            want.new_handle = {gen_count[i], IDX_FIELD_W'(i)};
                            want.alloc_ok   = 1'b1;
                            if (i > peak_slot)
                                peak_slot = i;
                        end
                MODE_QUERY:
                    want.still_waiting = hit;
                MODE_DONE:
                    if (hit)
                        gen_count[idx]++;    // wraps 0xffff -> 0
                default:
                    wipe();
            endcase
            awaited.push_back(want);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] beat);
            answer_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: result beat %h with no request outstanding", $time, beat);
                return;
            end
            want = awaited.pop_front();
            if (beat[HANDLE_W-1:0] !== want.new_handle)
            begin
                errors++;
                $display("%0t: new_handle expected %h, got %h",
                         $time, want.new_handle, beat[HANDLE_W-1:0]);
            end
            if (beat[OK_BIT] !== want.alloc_ok)
            begin
                errors++;
                $display("%0t: alloc_ok expected %b, got %b",
                         $time, want.alloc_ok, beat[OK_BIT]);
            end
            if (beat[WAIT_BIT] !== want.still_waiting)
            begin
                errors++;
                $display("%0t: still_waiting expected %b, got %b",
                         $time, want.still_waiting, beat[WAIT_BIT]);
            end
            if (beat[OUT_DATA_W-1:WAIT_BIT+1] !== '0)
            begin
                errors++;
                $display("%0t: pad bits expected 0, got %h",
                         $time, beat[OUT_DATA_W-1:WAIT_BIT+1]);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] handle
    logic [IN_USER_W-1:0]  s_axis_tuser  = MODE_ALLOC;   // [1:0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [31:0] new_handle, [32] alloc_ok,
                                           // [33] still_waiting, [39:34] zero

    generation_ledger ledger;
    bit               idle_on      = 1'b1;   // random stalls on both streams
    bit               hold_request = 1'b0;   // asks the sink for its long stall

    generation_handle_allocator #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Request side. tvalid is left high after an accept so back-to-back beats
    // never drop and raise it in the same step; the next call either parks
    // it low for a gap or presents the next beat straight away.
    // ------------------------------------------------------------------------
    task automatic send_request(mode_t mode, logic [HANDLE_W-1:0] handle);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= handle;
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // beat taken at this edge
        ledger.note_request(mode, handle);
    endtask

    // Random traffic: mostly handles that point at slots actually handed out,
    // some gone stale, plus raw noise and the odd clear.
    task automatic send_random_request();
        int unsigned      pick;
        int unsigned      slot;
        logic [GEN_W-1:0] gen;
        logic [HANDLE_W-1:0] handle;
        pick = $urandom_range(99);
        slot = $urandom_range(ledger.peak_slot + 1);
        if (slot >= TABLE_ENTRIES)
            slot = TABLE_ENTRIES - 1;
        gen = ledger.slot_gen(slot);
        if ($urandom_range(9) < 2)
            gen = gen ^ GEN_W'($urandom_range(1, 16'hffff));   // stale generation
        handle = {gen, IDX_FIELD_W'(slot)};
        if (pick < 40)
            send_request(MODE_ALLOC, $urandom());   // handle is don't-care here
        else if (pick < 60)
            send_request(MODE_QUERY, handle);
        else if (pick < 85)
            send_request(MODE_DONE, handle);
        else if (pick < 98)
            send_request((pick % 2 == 0) ? MODE_QUERY : MODE_DONE, $urandom());
        else
            send_request(MODE_CLEAR, $urandom());
    endtask

    // ------------------------------------------------------------------------
    // Result side: check on every accepted beat, random tready, and one long
    // hold-off when asked so the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                ledger.check_result(m_axis_tdata);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(99) < IDLE_PCT)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too many cycles with no beat on either stream ends the run.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [GEN_W-1:0] gen;
        int unsigned      slot;

        ledger = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // the block sweeps its table after reset; send_request just waits

        // --- directed: fresh table, matches, mismatches, range, clear ---
        send_request(MODE_QUERY, 32'h0000_0000);   // free slot, even gen matches
        send_request(MODE_ALLOC, 32'h0000_0000);
        send_request(MODE_ALLOC, 32'hffff_ffff);
        send_request(MODE_QUERY, 32'h0001_0000);   // live handle
        send_request(MODE_QUERY, 32'h0002_0000);   // wrong generation
        send_request(MODE_QUERY, {16'h0001, IDX_FIELD_W'(TABLE_ENTRIES)});   // first bad index
        send_request(MODE_QUERY, 32'h0000_ffff);   // top index
        send_request(MODE_DONE,  32'h0001_ffff);   // out of range, ignored
        send_request(MODE_DONE,  32'h0003_0001);   // mismatch, ignored
        send_request(MODE_DONE,  32'h0001_0000);   // frees slot 0
        send_request(MODE_QUERY, 32'h0001_0000);   // now stale
        send_request(MODE_ALLOC, 32'h0000_0000);   // reuses slot 0, gen 3
        send_request(MODE_DONE,  32'h0000_0002);   // done on a free even counter
        send_request(MODE_ALLOC, 32'h0000_0000);   // slot 2 taken by that done
        send_request(MODE_QUERY, {16'h0000, IDX_FIELD_W'(TABLE_ENTRIES - 1)});
        send_request(MODE_QUERY, {16'h0001, IDX_FIELD_W'(TABLE_ENTRIES - 1)});
        send_request(MODE_DONE,  32'hffff_ffff);
        send_request(MODE_QUERY, 32'hffff_ffff);
        send_request(MODE_CLEAR, 32'hffff_ffff);
        send_request(MODE_QUERY, 32'h0001_0001);   // gone after clear
        send_request(MODE_ALLOC, 32'h0000_0000);

        // --- cycle slot 0 between in use and free ---
        // Runs without stalls: this is the long no-idle stretch. Slot 0 is the
        // lowest slot, so each allocate lands on it again.
        idle_on = 1'b0;
        repeat (CYCLE_ROUNDS)
        begin
            gen = ledger.slot_gen(0);
            send_request(MODE_QUERY, {gen, 16'h0000});
            if (gen[0])
                send_request(MODE_DONE, {gen, 16'h0000});
            else
                send_request(MODE_ALLOC, 32'h0000_0000);
        end
        idle_on = 1'b1;

        // --- fill the table past full, free a few, take them back ---
        send_request(MODE_CLEAR, 32'h0000_0000);
        repeat (TABLE_ENTRIES + 3)
            send_request(MODE_ALLOC, $urandom());
        repeat (4)
        begin
            slot = $urandom_range(TABLE_ENTRIES - 1);
            send_request(MODE_DONE, {ledger.slot_gen(slot), IDX_FIELD_W'(slot)});
        end
        repeat (5)
            send_request(MODE_ALLOC, $urandom());

        // --- random mix; one long sink stall early on ---
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 200)
                hold_request = 1'b1;
            send_random_request();
        end
        s_axis_tvalid <= 1'b0;

        // let every answer come back, then watch for strays
        while (ledger.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.errors == 0 && ledger.pending_count() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/gha_pkg.sv
hw/rtl/gha_ram.sv
hw/rtl/gha_first_free.sv
hw/rtl/generation_handle_allocator.sv
hw/rtl/gha_checker.sv
sim/tb_generation_handle_allocator.sv
